/* rtl/core/bmf_pkg.sv */
// Shared constants for the byte image mode filter.
// Used by the interfaces, the top level and the checker.
// No dependencies.
package bmf_pkg;

  localparam int PIX_W          = 8;
  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_WINDOW_DEF = 7;

  localparam int WIDTH_W  = 12;
  localparam int HEIGHT_W = 16;
  localparam int WSIZE_W  = 3;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE  = 2'd2;

  localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 12'd512;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 16'd512;
  localparam logic [WSIZE_W-1:0]  WSIZE_RST  = 3'd3;

endpackage

/* rtl/core/bmf_if.sv */
// Valid/ready channel interfaces for pixel items and result items.
// Depends on bmf_pkg for the pixel width.
interface bmf_in_if;
  logic                       valid;
  logic                       ready;
  logic [bmf_pkg::PIX_W-1:0]  pixel_in;
  logic                       flush;
  modport source (output valid, pixel_in, flush, input ready);
  modport sink   (input valid, pixel_in, flush, output ready);
endinterface

interface bmf_out_if;
  logic                       valid;
  logic                       ready;
  logic [bmf_pkg::PIX_W-1:0]  out_pixel;
  logic                       frame_last;
  modport source (output valid, out_pixel, frame_last, input ready);
  modport sink   (input valid, out_pixel, frame_last, output ready);
endinterface

/* rtl/core/bmf_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/byte_image_mode_filter.sv */
// Top level of the byte image mode filter: sequencer, window registers, match counter.
// Depends on bmf_pkg, bmf_if and bmf_ram.
//
//  channel   direction  handshake            payload
//  in_chan   in         valid/ready          pixel_in[7:0], flush
//  out_chan  out        valid/ready          out_pixel[7:0], frame_last
//  cfg_*     in         cfg_we, no wait      cfg_index[1:0], cfg_data[15:0]
//
// A pixel item without a result is accepted in S_IDLE and written back to the line RAM in
// S_TAKE; a flush item passes through S_REST. A border result goes through S_EVAL and S_DONE
// after S_TAKE or after a drain item; an interior result also passes S_COUNT, one window position per cycle.
// After reset the line RAM is zeroed, all MAX_WIDTH addresses in S_CLEAR, with in_chan.ready low.
// A finished result waits in the output register; a further result waits until it drains.
module byte_image_mode_filter #(
  parameter int MAX_WIDTH  = bmf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_WINDOW = bmf_pkg::MAX_WINDOW_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [bmf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bmf_pkg::CFG_DATA_W-1:0] cfg_data,
  bmf_in_if.sink                         in_chan,
  bmf_out_if.source                      out_chan
);

  localparam int PW       = bmf_pkg::PIX_W;
  localparam int RW       = bmf_pkg::HEIGHT_W;
  localparam int MAX_HALF = (MAX_WINDOW - 1) / 2;
  localparam int EW       = $clog2(MAX_HALF + 1);
  localparam int IW       = $clog2(MAX_WINDOW);
  localparam int CW       = $clog2(MAX_WIDTH + 1);
  localparam int AW       = $clog2(MAX_WIDTH);
  localparam int LW       = $clog2(MAX_HALF * MAX_WIDTH + MAX_HALF + 1);
  localparam int LBW      = (MAX_WINDOW - 1) * PW;
  localparam int NWIN     = MAX_WINDOW * MAX_WINDOW;
  localparam int MW       = $clog2(NWIN + 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_TAKE, S_EVAL, S_COUNT, S_DONE, S_REST
  } state_t;

  state_t                       state_r;
  logic [bmf_pkg::WIDTH_W-1:0]  width_r;
  logic [bmf_pkg::HEIGHT_W-1:0] height_r;
  logic [bmf_pkg::WSIZE_W-1:0]  wsize_r;
  logic [CW-1:0]                in_col_r, out_col_r, col_r;
  logic [RW-1:0]                in_row_r, out_row_r;
  logic [LW-1:0]                pos_r;
  logic [PW-1:0]                px_r;
  logic                         emit_r;
  logic [AW-1:0]                clr_r;
  logic [PW-1:0]                win_r [MAX_WINDOW][MAX_WINDOW];
  logic [IW-1:0]                cr_r, cc_r;
  logic [MW-1:0]                best_cnt_r;
  logic [PW-1:0]                best_val_r, center_r;
  logic                         border_r, last_r;
  logic                         out_valid_r;
  logic [PW-1:0]                out_pix_r;
  logic                         out_last_r;

  logic [CW-1:0]  w_eff;
  logic [RW-1:0]  h_eff;
  logic [1:0]     e_raw;
  logic [EW-1:0]  e_eff;
  int             side_i, e_i;
  logic [LW-1:0]  lag;
  logic           in_acc, input_done;
  logic [CW-1:0]  col_eff, in_col_inc, out_col_inc;
  logic           border, last;

  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic [LBW-1:0] ram_wdata, ram_rdata;

  logic [PW-1:0]  ld [MAX_WINDOW];
  logic [PW-1:0]  win_nxt [MAX_WINDOW][MAX_WINDOW];
  logic [PW-1:0]  cand;
  logic [NWIN-1:0] mask;
  logic [MW-1:0]  cnt;
  logic           take_best, cand_last, col_wrap;

  // Effective geometry from the configuration registers.
  always_comb begin
    if (width_r == '0) begin
      w_eff = CW'(1);
    end else if (32'(width_r) > 32'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(width_r);
    end
    h_eff = (height_r == '0) ? RW'(1) : height_r;
    e_raw = (wsize_r == '0) ? 2'd0 : 2'((wsize_r - 3'd1) >> 1);
    if (32'(e_raw) > 32'(MAX_HALF)) begin
      e_eff = EW'(MAX_HALF);
    end else begin
      e_eff = EW'(e_raw);
    end
    e_i    = int'(e_eff);
    side_i = 2 * e_i + 1;
    lag    = LW'(LW'(w_eff) * LW'(e_eff) + LW'(e_eff));
  end

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign input_done    = (in_row_r >= h_eff);
  assign col_eff       = (in_col_r >= w_eff) ? (w_eff - CW'(1)) : in_col_r;
  assign in_col_inc    = col_eff + CW'(1);
  assign out_col_inc   = out_col_r + CW'(1);

  assign border = (int'(out_row_r) < e_i) || (int'(out_col_r) < e_i) ||
                  (int'(out_row_r) + e_i >= int'(h_eff)) ||
                  (int'(out_col_r) + e_i >= int'(w_eff));
  assign last   = (int'(out_row_r) + 1 >= int'(h_eff)) &&
                  (int'(out_col_r) + 1 >= int'(w_eff));

  // Window shift and line storage update for the pixel held in px_r.
  always_comb begin
    for (int r = 0; r < MAX_WINDOW - 1; r++) begin
      ld[r] = ram_rdata[r*PW +: PW];
    end
    ld[MAX_WINDOW-1] = px_r;
    win_nxt = win_r;
    for (int r = 0; r < MAX_WINDOW; r++) begin
      for (int c = 0; c < MAX_WINDOW; c++) begin
        if (r < side_i && c < side_i) begin
          if (c + 1 < side_i) begin
            win_nxt[r][c] = win_r[r][c+1];
          end else if (r + 1 < side_i) begin
            win_nxt[r][c] = ld[r];
          end else begin
            win_nxt[r][c] = px_r;
          end
        end
      end
    end
    for (int r = 0; r < MAX_WINDOW - 1; r++) begin
      if (r + 1 < 2 * e_i) begin
        ram_wdata[r*PW +: PW] = ld[r+1];
      end else if (r + 1 == 2 * e_i) begin
        ram_wdata[r*PW +: PW] = px_r;
      end else begin
        ram_wdata[r*PW +: PW] = ld[r];
      end
    end
    if (state_r == S_CLEAR) begin
      ram_wdata = '0;
    end
  end

  assign ram_we    = (state_r == S_CLEAR) || (state_r == S_TAKE);
  assign ram_waddr = (state_r == S_CLEAR) ? clr_r : col_r[AW-1:0];

  bmf_ram #(
    .WIDTH (LBW),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (col_eff[AW-1:0]),
    .rdata (ram_rdata)
  );

  // Match counter: one candidate position against the whole window per cycle.
  always_comb begin
    cand = win_r[cr_r][cc_r];
    mask = '0;
    for (int r = 0; r < MAX_WINDOW; r++) begin
      for (int c = 0; c < MAX_WINDOW; c++) begin
        mask[r*MAX_WINDOW+c] = (r < side_i) && (c < side_i) && (win_r[r][c] == cand);
      end
    end
    cnt       = MW'($countones(mask));
    take_best = (cnt > best_cnt_r) ||
                ((cnt == best_cnt_r) && (cnt >= MW'(2)) && (cand < best_val_r));
    col_wrap  = (int'(cc_r) + 1 == side_i);
    cand_last = col_wrap && (int'(cr_r) + 1 == side_i);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      width_r     <= bmf_pkg::WIDTH_RST;
      height_r    <= bmf_pkg::HEIGHT_RST;
      wsize_r     <= bmf_pkg::WSIZE_RST;
      in_col_r    <= '0;
      in_row_r    <= '0;
      out_col_r   <= '0;
      out_row_r   <= '0;
      pos_r       <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      for (int r = 0; r < MAX_WINDOW; r++) begin
        for (int c = 0; c < MAX_WINDOW; c++) begin
          win_r[r][c] <= '0;
        end
      end
    end else begin
      // In S_DONE the new result decides the valid flag itself.
      if (out_valid_r && out_chan.ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + AW'(1);
          if (32'(clr_r) == 32'(MAX_WIDTH - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            if (input_done) begin
              state_r <= S_EVAL;
            end else if (in_chan.flush) begin
              state_r <= S_REST;
            end else begin
              px_r   <= in_chan.pixel_in;
              col_r  <= col_eff;
              emit_r <= (pos_r >= lag);
              if (pos_r < lag) begin
                pos_r <= pos_r + LW'(1);
              end
              if (in_col_inc >= w_eff) begin
                in_col_r <= '0;
                in_row_r <= in_row_r + RW'(1);
              end else begin
                in_col_r <= in_col_inc;
              end
              state_r <= S_TAKE;
            end
          end
        end
        S_TAKE: begin
          win_r   <= win_nxt;
          state_r <= emit_r ? S_EVAL : S_IDLE;
        end
        S_EVAL: begin
          border_r   <= border;
          last_r     <= last;
          cr_r       <= '0;
          cc_r       <= '0;
          best_cnt_r <= MW'(1);
          best_val_r <= '0;
          if (last) begin
            in_col_r  <= '0;
            in_row_r  <= '0;
            out_col_r <= '0;
            out_row_r <= '0;
            pos_r     <= '0;
          end else if (out_col_inc >= w_eff) begin
            out_col_r <= '0;
            out_row_r <= out_row_r + RW'(1);
          end else begin
            out_col_r <= out_col_inc;
          end
          state_r <= border ? S_DONE : S_COUNT;
        end
        S_COUNT: begin
          if (take_best) begin
            best_cnt_r <= cnt;
            best_val_r <= cand;
          end
          if (int'(cr_r) == e_i && int'(cc_r) == e_i) begin
            center_r <= cand;
          end
          if (col_wrap) begin
            cc_r <= '0;
            cr_r <= cr_r + IW'(1);
          end else begin
            cc_r <= cc_r + IW'(1);
          end
          if (cand_last) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_chan.ready) begin
            out_valid_r <= 1'b1;
            out_last_r  <= last_r;
            if (border_r) begin
              out_pix_r <= '0;
            end else if (best_cnt_r >= MW'(2)) begin
              out_pix_r <= best_val_r;
            end else begin
              out_pix_r <= center_r;
            end
            state_r <= S_IDLE;
          end
        end
        S_REST: begin
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
      // A write to the width, height or window size register restarts the frame; stored pixels stay.
      if (cfg_we) begin
        case (cfg_index)
          bmf_pkg::CFG_IMAGE_WIDTH:  width_r  <= cfg_data[bmf_pkg::WIDTH_W-1:0];
          bmf_pkg::CFG_IMAGE_HEIGHT: height_r <= cfg_data[bmf_pkg::HEIGHT_W-1:0];
          bmf_pkg::CFG_WINDOW_SIZE:  wsize_r  <= cfg_data[bmf_pkg::WSIZE_W-1:0];
          default: ;
        endcase
        if (cfg_index == bmf_pkg::CFG_IMAGE_WIDTH ||
            cfg_index == bmf_pkg::CFG_IMAGE_HEIGHT ||
            cfg_index == bmf_pkg::CFG_WINDOW_SIZE) begin
          in_col_r  <= '0;
          in_row_r  <= '0;
          out_col_r <= '0;
          out_row_r <= '0;
          pos_r     <= '0;
        end
      end
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.out_pixel  = out_pix_r;
  assign out_chan.frame_last = out_last_r;

endmodule

/* rtl/core/bmf_checker.sv */
// Port-level checks for the byte image mode filter, bound to the top level.
// Depends on bmf_pkg and on the port names of byte_image_mode_filter.
module bmf_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [bmf_pkg::PIX_W-1:0] out_pixel,
  input logic                      frame_last
);

  // A held result stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  // Every accepted item takes the sequencer out of S_IDLE, so in_ready is low in the cycle after the accept.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted on two consecutive cycles");

  // Right after reset the line RAM is being cleared and no result exists.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("block active right after reset");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_pixel) && $stable(frame_last))
    else $error("result payload changed while stalled");

endmodule

bind byte_image_mode_filter bmf_checker u_bmf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_chan.valid),
  .in_ready   (in_chan.ready),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .out_pixel  (out_chan.out_pixel),
  .frame_last (out_chan.frame_last)
);
